// ----- rtl/core/eas_pkg.sv -----
package eas_pkg;

   localparam int ENTITY_COUNT    = 64;
   localparam int COMPONENT_COUNT = 32;

   localparam int CMD_W  = 2;
   localparam int ID_W   = 6;
   localparam int COMP_W = 5;
   localparam int MASK_W = 32;
   localparam int STAT_W = 2;

   localparam int RAM_AW      = $clog2(ENTITY_COUNT);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SET     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] ST_IGNORED = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ID_W-1:0]   entity_id;
      logic [COMP_W-1:0] component_index;
      logic [MASK_W-1:0] query_mask;
      logic              match_mode;
   } eas_req_type;

   typedef struct packed {
      logic [ID_W-1:0]   result_id;
      logic [STAT_W-1:0] status;
      logic              last;
   } eas_rsp_type;

   // classified command as held in the queue
   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ID_W-1:0]   entity_id;
      logic              eid_ok;
      logic              comp_ok;
      logic [MASK_W-1:0] comp_bit;
      logic [MASK_W-1:0] query_mask;
      logic              match_mode;
   } eas_item_type;

endpackage

// ----- rtl/core/entity_allocator_signature_match_core.sv -----
// Entity table with per-entity component masks.
// Request channel (req_valid/req_stall/req_data) takes one command per beat:
// allocate, destroy, set component or query. Responses leave on the rsp_
// channel; every command gives one beat with last set, except a query, which
// gives one beat per matching in-use entity in ascending id order, last on
// the final one, or a single no-match beat.
// A two-entry queue sits between the front end and the sequencer, so requests
// are taken while a response waits on rsp_stall.
// Set component passes through a mask write state before its response state;
// destroy goes straight to the response state; allocate walks to the lowest free id; query walks the whole table.
// The sequencer does one command at a time; allocate and query walk the table
// one slot per cycle, a query only while no further hit waits on rsp_stall;
// a query reads masks through the mask RAM read port and occupies the sequencer
// for its whole walk plus every stall on a further hit or on the final beat.
// A stalled response holds its beat and halts the walk; the queue then fills
// and req_stall rises.
// Synchronous reset frees every entity and clears every mask at once through
// per-entry valid bits; no clearing pass.
module entity_allocator_signature_match_core import eas_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  eas_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output eas_rsp_type rsp_data
);

   logic         q_valid;
   eas_item_type q_item;
   logic         q_pop;

   eas_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   eas_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/core/eas_ram.sv -----
module eas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/eas_front.sv -----
module eas_front import eas_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  eas_req_type  req_data,
   output logic         q_valid,
   output eas_item_type q_item,
   input  logic         q_pop
);

   eas_item_type          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   eas_item_type          cls;
   logic                  push;
   logic                  pop;

   always_comb begin
      cls.command    = req_data.command;
      cls.entity_id  = req_data.entity_id;
      cls.eid_ok     = int'(req_data.entity_id) < ENTITY_COUNT;
      cls.comp_ok    = int'(req_data.component_index) < COMPONENT_COUNT;
      cls.comp_bit   = MASK_W'(1) << req_data.component_index;
      cls.query_mask = req_data.query_mask;
      cls.match_mode = req_data.match_mode;
   end

   assign req_stall = count_ff == QUEUE_CW'(QUEUE_DEPTH);
   assign push      = req_valid && !req_stall;
   assign q_valid   = count_ff != '0;
   assign pop       = q_pop && q_valid;
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- rtl/core/eas_back.sv -----
module eas_back import eas_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  eas_item_type q_item,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output eas_rsp_type  rsp_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ALLOC = 3'd1;
   localparam logic [2:0] S_SETWR = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   localparam logic [ID_W-1:0] ENTITY_LAST = ID_W'(ENTITY_COUNT - 1);

   logic [2:0]              state_ff, state_in;
   logic [ID_W-1:0]         idx_ff, idx_in;
   eas_item_type            item_ff, item_in;
   logic [ID_W-1:0]         held_id_ff, held_id_in;
   logic                    held_valid_ff, held_valid_in;
   eas_rsp_type             pend_ff, pend_in;
   logic [ENTITY_COUNT-1:0] in_use_ff, in_use_in;
   logic [ENTITY_COUNT-1:0] mask_valid_ff, mask_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   eas_rsp_type             rsp_data_ff, rsp_data_in;

   logic              out_free;
   logic              push;
   eas_rsp_type       push_data;
   logic              ram_we;
   logic [MASK_W-1:0] ram_wdata;
   logic [MASK_W-1:0] ram_rdata;
   logic [MASK_W-1:0] mask_cur;
   logic              hit;

   function automatic logic sig_match(logic [MASK_W-1:0] q, logic [MASK_W-1:0] m,
                                      logic mode);
      logic [MASK_W-1:0] both;
      both = q & m;
      return mode ? (both == m) : (both == q);
   endfunction

   // read address follows the next index, so rdata always belongs to idx_ff
   eas_ram #(
      .WIDTH (MASK_W),
      .DEPTH (ENTITY_COUNT)
   ) u_masks (
      .clock (clock),
      .we    (ram_we),
      .waddr (idx_ff[RAM_AW-1:0]),
      .wdata (ram_wdata),
      .raddr (idx_in[RAM_AW-1:0]),
      .rdata (ram_rdata)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign mask_cur = mask_valid_ff[idx_ff] ? ram_rdata : '0;
   assign hit      = in_use_ff[idx_ff] && sig_match(item_ff.query_mask, mask_cur,
                                                    item_ff.match_mode);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      item_in       = item_ff;
      held_id_in    = held_id_ff;
      held_valid_in = held_valid_ff;
      pend_in       = pend_ff;
      in_use_in     = in_use_ff;
      mask_valid_in = mask_valid_ff;
      q_pop         = 1'b0;
      push          = 1'b0;
      push_data     = pend_ff;
      ram_we        = 1'b0;
      ram_wdata     = mask_cur | item_ff.comp_bit;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop         = 1'b1;
               item_in       = q_item;
               idx_in        = '0;
               held_valid_in = 1'b0;
               unique case (q_item.command)
                  CMD_ALLOC: begin
                     state_in = S_ALLOC;
                  end
                  CMD_DESTROY: begin
                     state_in = S_RESP;
                     if (q_item.eid_ok && mask_valid_ff[q_item.entity_id]) begin
                        mask_valid_in[q_item.entity_id] = 1'b0;
                        in_use_in[q_item.entity_id]     = 1'b0;
                        pend_in = '{result_id: '0, status: ST_OK, last: 1'b1};
                     end else begin
                        pend_in = '{result_id: '0, status: ST_IGNORED, last: 1'b1};
                     end
                  end
                  CMD_SET: begin
                     pend_in = '{result_id: '0, status: ST_OK, last: 1'b1};
                     if (q_item.eid_ok && q_item.comp_ok) begin
                        idx_in   = q_item.entity_id;
                        state_in = S_SETWR;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  CMD_QUERY: begin
                     state_in = S_SCAN;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            if (!in_use_ff[idx_ff]) begin
               in_use_in[idx_ff] = 1'b1;
               pend_in  = '{result_id: idx_ff, status: ST_OK, last: 1'b1};
               state_in = S_RESP;
            end else if (idx_ff == ENTITY_LAST) begin
               pend_in  = '{result_id: '0, status: ST_FULL, last: 1'b1};
               state_in = S_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SETWR: begin
            ram_we                = 1'b1;
            mask_valid_in[idx_ff] = 1'b1;
            state_in              = S_RESP;
         end
         S_SCAN: begin
            // a hit is held back one step so the final one can carry last
            if (!(hit && held_valid_ff) || out_free) begin
               if (hit) begin
                  held_id_in    = idx_ff;
                  held_valid_in = 1'b1;
                  if (held_valid_ff) begin
                     push      = 1'b1;
                     push_data = '{result_id: held_id_ff, status: ST_OK, last: 1'b0};
                  end
               end
               if (idx_ff == ENTITY_LAST) begin
                  state_in = S_RESP;
                  if (hit) begin
                     pend_in = '{result_id: idx_ff, status: ST_OK, last: 1'b1};
                  end else if (held_valid_ff) begin
                     pend_in = '{result_id: held_id_ff, status: ST_OK, last: 1'b1};
                  end else begin
                     pend_in = '{result_id: '0, status: ST_NOMATCH, last: 1'b1};
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         held_valid_ff <= 1'b0;
         in_use_ff     <= '0;
         mask_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_valid_ff <= held_valid_in;
         in_use_ff     <= in_use_in;
         mask_valid_ff <= mask_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      item_ff     <= item_in;
      held_id_ff  <= held_id_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/core/eas_checker.sv -----
module eas_checker import eas_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input eas_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input eas_rsp_type rsp_data
);

   // a stalled response beat stays and holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response beat dropped or changed under stall");

   // full, ignored and no-match are single-beat answers with id zero
   a_status_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.last && rsp_data.result_id == '0)
      else $error("non-ok status without last or with nonzero id");

   // nothing leaves the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   // a beat that follows a taken non-final beat without a gap has ok status
   a_query_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last ##1 rsp_valid
      |-> rsp_data.status == ST_OK)
      else $error("beat after a non-final query beat has non-ok status");

endmodule

bind entity_allocator_signature_match_core eas_checker u_eas_checker (.*);
